// ----- rtl/annexb_nal_unit_splitter_macros.svh -----
// Assertion macros for the Annex B NAL unit splitter.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ANBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ANBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/anbs_pkg.sv -----
// Shared types, constants and helpers for the Annex B NAL unit splitter.
`default_nettype none

package anbs_pkg;

    localparam int unsigned MAX_NAL_BYTES = 65535;
    localparam int unsigned LEN_W         = 16;
    localparam logic [LEN_W-1:0] LEN_CAP  =
        (MAX_NAL_BYTES < 65535) ? LEN_W'(MAX_NAL_BYTES) : {LEN_W{1'b1}};

    localparam int unsigned WIN_DEPTH   = 3;
    localparam int unsigned MAX_BURST   = 5;
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BURST_W     = $clog2(MAX_BURST + 1);
    localparam logic [QCNT_W-1:0] READY_LIMIT = QCNT_W'(QUEUE_DEPTH - MAX_BURST);

    localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
    localparam logic [7:0] HDR_REF_MASK       = 8'h60;
    localparam logic [7:0] HDR_TYPE_MASK      = 8'h1f;
    localparam logic [7:0] SC_ZERO            = 8'h00;
    localparam logic [7:0] SC_ONE             = 8'h01;
    localparam logic [LEN_W-1:0] PLEN_SHORT   = LEN_W'(3);
    localparam logic [LEN_W-1:0] PLEN_LONG    = LEN_W'(4);

    typedef struct packed {
        logic [7:0]       data_out;
        logic             nal_first;
        logic             nal_last;
        logic             prefix_long;
        logic             hdr_fbit;
        logic [1:0]       ref_idc;
        logic [4:0]       unit_type;
        logic [LEN_W-1:0] nal_length;
        logic             sync_error;
    } t_res;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    function automatic t_res nal_word(input logic [7:0] d, input logic first,
                                      input logic last, input logic plong,
                                      input logic [LEN_W-1:0] len);
        t_res       r;
        logic [7:0] ref_bits;
        logic [7:0] type_bits;
        ref_bits        = d & HDR_REF_MASK;
        type_bits       = d & HDR_TYPE_MASK;
        r               = '0;
        r.data_out      = d;
        r.nal_first     = first;
        r.nal_last      = last;
        r.prefix_long   = first & plong;
        r.hdr_fbit      = first & (|(d & HDR_FORBIDDEN_MASK));
        r.ref_idc       = first ? ref_bits[6:5] : 2'b00;
        r.unit_type     = first ? type_bits[4:0] : 5'b00000;
        r.nal_length    = last ? len : '0;
        r.sync_error    = 1'b0;
        return r;
    endfunction

    function automatic t_res error_word();
        t_res r;
        r            = '0;
        r.sync_error = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/anbs_if.sv -----
// Valid/ready channel interfaces for the stream input and the NAL output.
`default_nettype none

interface anbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       stream_end;

    modport source (output valid, output data_in, output stream_end, input ready);
    modport sink   (input valid, input data_in, input stream_end, output ready);
endinterface

interface anbs_out_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   data_out;
    logic                         nal_first;
    logic                         nal_last;
    logic                         prefix_long;
    logic                         hdr_fbit;
    logic [1:0]                   ref_idc;
    logic [4:0]                   unit_type;
    logic [anbs_pkg::LEN_W-1:0]   nal_length;
    logic                         sync_error;

    modport source (output valid, output data_out, output nal_first, output nal_last,
                    output prefix_long, output hdr_fbit, output ref_idc,
                    output unit_type, output nal_length, output sync_error,
                    input ready);
    modport sink   (input valid, input data_out, input nal_first, input nal_last,
                    input prefix_long, input hdr_fbit, input ref_idc,
                    input unit_type, input nal_length, input sync_error,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/anbs_core.sv -----
// Start code parser: byte window, held byte and unit state; builds result words.
`default_nettype none

module anbs_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_acc,
    input  wire logic [7:0]                      i_data,
    input  wire logic                            i_end,
    output logic [anbs_pkg::BURST_W-1:0]         o_count,
    output anbs_pkg::t_res                       o_words [anbs_pkg::QUEUE_DEPTH]
);

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_RESYNC,
        PH_NAL
    } t_phase;

    t_phase                     r_phase;
    logic [7:0]                 r_win [anbs_pkg::WIN_DEPTH];
    logic [1:0]                 r_fill;
    logic [7:0]                 r_held;
    logic                       r_held_v;
    logic                       r_plong;
    logic                       r_hdr;
    logic [anbs_pkg::LEN_W-1:0] r_cnt;

    logic [7:0]                 w  [anbs_pkg::WIN_DEPTH + 1];
    logic [7:0]                 ev [anbs_pkg::MAX_BURST];
    logic [anbs_pkg::WIN_DEPTH-1:0] z;
    logic                       b_one;
    logic                       long4;
    logic                       short3;
    logic                       found;
    logic                       seek_ok;
    logic                       in_nal;
    logic                       err;
    logic [2:0]                 c_k;
    logic                       c_fin;
    logic [2:0]                 total;
    logic [2:0]                 emit_n;
    logic [anbs_pkg::LEN_W:0]   len_sum;
    logic [anbs_pkg::LEN_W-1:0] len_new;

    always_comb begin
        for (int i = 0; i < anbs_pkg::WIN_DEPTH; i++) begin
            if (2'(i) < r_fill) begin
                w[i] = r_win[i];
            end else if (2'(i) == r_fill) begin
                w[i] = i_data;
            end else begin
                w[i] = '0;
            end
        end
        w[anbs_pkg::WIN_DEPTH] = (r_fill == 2'd3) ? i_data : 8'h00;
        for (int i = 0; i < anbs_pkg::WIN_DEPTH; i++) begin
            z[i] = (w[i] == anbs_pkg::SC_ZERO);
        end
    end

    assign b_one   = (i_data == anbs_pkg::SC_ONE);
    assign long4   = (r_fill == 2'd3) && z[0] && z[1] && z[2] && b_one;
    assign short3  = b_one && (((r_fill == 2'd2) && z[0] && z[1]) ||
                               ((r_fill == 2'd3) && z[1] && z[2]));
    assign found   = long4 || short3;
    assign seek_ok = (r_fill < 2'd2) || ((r_fill == 2'd2) && z[0] && z[1] && z[2]);
    assign in_nal  = (r_phase == PH_NAL);
    assign err     = (r_phase == PH_SEEK) && !found && !seek_ok;

    always_comb begin
        if (in_nal && found) begin
            c_k   = (short3 && !long4 && (r_fill == 2'd3)) ? 3'd1 : 3'd0;
            c_fin = 1'b1;
        end else if (in_nal && i_end) begin
            c_k   = 3'(r_fill) + 3'd1;
            c_fin = 1'b1;
        end else if (in_nal) begin
            c_k   = (r_fill == 2'd3) ? 3'd1 : 3'd0;
            c_fin = 1'b0;
        end else begin
            c_k   = 3'd0;
            c_fin = 1'b0;
        end
    end

    assign total   = 3'(r_held_v) + c_k;
    assign emit_n  = c_fin ? total : ((total != 3'd0) ? total - 3'd1 : 3'd0);
    assign len_sum = {1'b0, r_cnt} + (anbs_pkg::LEN_W + 1)'(c_k);
    assign len_new = (len_sum > {1'b0, anbs_pkg::LEN_CAP}) ? anbs_pkg::LEN_CAP
                                                          : len_sum[anbs_pkg::LEN_W-1:0];

    always_comb begin
        ev[0] = r_held_v ? r_held : w[0];
        for (int j = 1; j < anbs_pkg::MAX_BURST - 1; j++) begin
            ev[j] = r_held_v ? w[j-1] : w[j];
        end
        ev[anbs_pkg::MAX_BURST-1] = w[anbs_pkg::WIN_DEPTH];
    end

    always_comb begin
        for (int j = 0; j < anbs_pkg::QUEUE_DEPTH; j++) begin
            o_words[j] = '0;
        end
        if (err) begin
            o_words[0] = anbs_pkg::error_word();
        end else begin
            for (int j = 0; j < anbs_pkg::MAX_BURST; j++) begin
                if (3'(j) < emit_n) begin
                    o_words[j] = anbs_pkg::nal_word(ev[j], r_hdr && (j == 0),
                                                    c_fin && (3'(j) == emit_n - 3'd1),
                                                    r_plong, len_new);
                end
            end
        end
    end

    assign o_count = err ? anbs_pkg::BURST_W'(1) : anbs_pkg::BURST_W'(emit_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEEK;
            r_fill   <= '0;
            r_held_v <= 1'b0;
            r_plong  <= 1'b0;
            r_hdr    <= 1'b0;
            r_cnt    <= '0;
        end else if (i_acc) begin
            if (i_end) begin
                r_phase  <= PH_SEEK;
                r_fill   <= '0;
                r_held_v <= 1'b0;
                r_plong  <= 1'b0;
                r_hdr    <= 1'b0;
                r_cnt    <= '0;
            end else if (found) begin
                r_phase  <= PH_NAL;
                r_fill   <= '0;
                r_held_v <= 1'b0;
                r_plong  <= long4;
                r_hdr    <= 1'b1;
                r_cnt    <= long4 ? anbs_pkg::PLEN_LONG : anbs_pkg::PLEN_SHORT;
            end else begin
                if (r_fill != 2'd3) begin
                    r_win[r_fill] <= i_data;
                    r_fill        <= r_fill + 2'd1;
                end else begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= i_data;
                end
                if (err) begin
                    r_phase <= PH_RESYNC;
                end
                if (in_nal) begin
                    r_cnt <= len_new;
                    if (emit_n != 3'd0) begin
                        r_hdr <= 1'b0;
                    end
                    if (c_k != 3'd0) begin
                        r_held   <= w[0];
                        r_held_v <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/anbs_cell.sv -----
// One output queue cell: loads a new word, takes its neighbor's word, or holds.
`default_nettype none

module anbs_cell (
    input  wire logic                 i_clk,
    input  anbs_pkg::t_cell_ctl       i_ctl,
    input  anbs_pkg::t_res            i_new,
    input  anbs_pkg::t_res            i_next,
    output anbs_pkg::t_res            o_word
);

    anbs_pkg::t_res r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_new;
        end else if (i_ctl.shift) begin
            r_word <= i_next;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ----- rtl/annexb_nal_unit_splitter.sv -----
// Annex B NAL unit splitter top level: parser plus a row of output queue cells.
//
// Input channel i_in carries one stream byte per word (data_in) with stream_end
// set on the last byte of a stream. Output channel o_out carries one NAL byte
// per word after the start code, with nal_first (header fields valid),
// nal_last (nal_length valid) and sync_error on the single error word emitted
// when a stream does not open with a start code.
// Throughput: one input word per cycle while i_in.ready is high; output drains
// one word per cycle while o_out.ready is high. A committed byte is registered
// in a queue cell and reaches o_out from the queue head. Bytes that may belong
// to a start code, plus one held byte, wait for later input, so data trails
// the input by up to four words; stream_end flushes them. A word may produce
// up to five output words (flush at stream end); they enter an eight-cell
// shift queue, and i_in.ready stays high while at least five cells are free,
// so ready depends only on the queue fill register. When the receiver stalls,
// the head word holds and the queue fills; input then stops until room returns.
// Reset (synchronous, active low) empties the queue and returns the parser to
// seeking the first start code; no clearing pass is needed.
`default_nettype none
`include "annexb_nal_unit_splitter_macros.svh"

module annexb_nal_unit_splitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    anbs_in_if.sink          i_in,
    anbs_out_if.source       o_out
);

    logic [anbs_pkg::QCNT_W-1:0]  r_cnt;
    logic [anbs_pkg::BURST_W-1:0] core_count;
    anbs_pkg::t_res               core_words [anbs_pkg::QUEUE_DEPTH];
    anbs_pkg::t_res               q          [anbs_pkg::QUEUE_DEPTH];
    logic                         acc;
    logic                         pop;
    logic [anbs_pkg::QCNT_W-1:0]  base;
    logic [anbs_pkg::QCNT_W-1:0]  push_n;

    assign i_in.ready = (r_cnt <= anbs_pkg::READY_LIMIT);
    assign acc        = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;
    assign base       = r_cnt - anbs_pkg::QCNT_W'(pop);
    assign push_n     = acc ? anbs_pkg::QCNT_W'(core_count) : '0;

    anbs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_data  (i_in.data_in),
        .i_end   (i_in.stream_end),
        .o_count (core_count),
        .o_words (core_words)
    );

    for (genvar gi = 0; gi < anbs_pkg::QUEUE_DEPTH; gi++) begin : g_cell
        logic [anbs_pkg::QCNT_W-1:0] off;
        anbs_pkg::t_cell_ctl         ctl;
        anbs_pkg::t_res              next_word;

        assign off       = anbs_pkg::QCNT_W'(gi) - base;
        assign ctl.load  = (anbs_pkg::QCNT_W'(gi) >= base) && (off < push_n);
        assign ctl.shift = pop;

        if (gi == anbs_pkg::QUEUE_DEPTH - 1) begin : g_tail
            assign next_word = '0;
        end else begin : g_body
            assign next_word = q[gi+1];
        end

        anbs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_new  (core_words[off[anbs_pkg::QIDX_W-1:0]]),
            .i_next (next_word),
            .o_word (q[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= base + push_n;
        end
    end

    assign o_out.valid         = (r_cnt != '0);
    assign o_out.data_out      = q[0].data_out;
    assign o_out.nal_first     = q[0].nal_first;
    assign o_out.nal_last      = q[0].nal_last;
    assign o_out.prefix_long   = q[0].prefix_long;
    assign o_out.hdr_fbit      = q[0].hdr_fbit;
    assign o_out.ref_idc       = q[0].ref_idc;
    assign o_out.unit_type     = q[0].unit_type;
    assign o_out.nal_length    = q[0].nal_length;
    assign o_out.sync_error    = q[0].sync_error;

    `ANBS_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, r_cnt <= anbs_pkg::QUEUE_DEPTH)
    `ANBS_ASSERT_NOW(a_error_clean, i_clk, i_rst_n, o_out.valid && o_out.sync_error, o_out.data_out == 8'h00 && !o_out.nal_first && !o_out.nal_last)
    `ANBS_ASSERT_NOW(a_last_length, i_clk, i_rst_n, o_out.valid && o_out.nal_last, o_out.nal_length >= anbs_pkg::PLEN_SHORT)
    `ANBS_ASSERT_NEXT(a_drain_step, i_clk, i_rst_n, pop && !acc, r_cnt == $past(r_cnt) - 1'b1)

endmodule

`default_nettype wire
